// ===== design/sbsi_pkg.sv =====
// Package for the segment/box slab intersect unit.
// Holds the widths used by the unit.
`default_nettype none
package sbsi_pkg;
   localparam int COORD_WIDTH = 32;
   localparam int T_FRAC_BITS = 16;
   localparam int THR_WIDTH   = 16;
endpackage
`default_nettype wire

// ===== design/sbsi_div_cell.sv =====
// One restoring-division step of a pipelined quotient chain.
// Depends on nothing but its parameters.
`default_nettype none
module sbsi_div_cell #(
   parameter int NW = 35,
   parameter int QW = 18
) (
   input  wire logic          clock,
   input  wire logic          advance,
   input  wire logic [NW-1:0] rem_in,
   input  wire logic [NW-1:0] den_in,
   input  wire logic [QW-1:0] quo_in,
   output logic      [NW-1:0] rem_ff,
   output logic      [NW-1:0] den_ff,
   output logic      [QW-1:0] quo_ff
);
   logic [NW:0] shifted;
   logic        ge;
   always_comb begin
      shifted = {rem_in, 1'b0};
      ge      = shifted >= {1'b0, den_in};
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= ge ? NW'(shifted - {1'b0, den_in}) : shifted[NW-1:0];
         den_ff <= den_in;
         quo_ff <= {quo_in[QW-2:0], ge};
      end
   end
endmodule
`default_nettype wire

// ===== design/segment_box_slab_intersect_unit.sv =====
// Top level: segment versus axis-aligned cube slab test.
// Depends on sbsi_pkg and sbsi_div_cell.
//  channel | dir | word
//  req     | in  | start, end, box centre, box edge
//  rsp     | out | hit, t_entry, t_exit, point
//  csr     | in  | parallel_threshold
// One word per cycle while rsp is not stalled. Pipeline: one setup
// stage, three axis stages of T_FRAC_BITS+1 divider cells each, then register,
// multiply and output stages.
// Synchronous reset clears the valid bits and sets the threshold to 1.
// A stall on rsp freezes the whole pipeline and drops req_tready with it.
`default_nettype none
module segment_box_slab_intersect_unit #(
   parameter int COORD_WIDTH = sbsi_pkg::COORD_WIDTH,
   parameter int T_FRAC_BITS = sbsi_pkg::T_FRAC_BITS
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // start_x,y,z, end_x,y,z, box_x,y,z, box_edge
   input  wire logic [((10*COORD_WIDTH-1+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // t_entry, t_exit, point_x, point_y, point_z
   output logic [((2*(T_FRAC_BITS+2)+3*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // hit
   output logic      rsp_tuser,
   input  wire logic csr_valid,
   output logic      csr_ready,
   input  wire logic [sbsi_pkg::THR_WIDTH-1:0] csr_data
);
   localparam int CW = COORD_WIDTH;
   localparam int TW = T_FRAC_BITS + 2;
   localparam int NW = CW + 3;
   localparam int QW = TW;
   localparam int NC = T_FRAC_BITS + 1;
   localparam int DEPTH = 1 + 3*NC + 3;
   localparam logic signed [TW:0] TONE = (TW+1)'(1) <<< T_FRAC_BITS;
   localparam logic signed [TW:0] TSAT = (TW+1)'(2) <<< T_FRAC_BITS;
   localparam int OW = ((2*TW+3*CW+7)/8)*8;
   localparam logic signed [CW+TW+1:0] PMAX = $signed({{(TW+3){1'b0}}, {(CW-1){1'b1}}});
   localparam logic signed [CW+TW+1:0] PMIN = -PMAX - 1;

   typedef struct packed {
      logic signed [CW-1:0] s;
      logic signed [CW:0]   d;
      logic signed [CW:0]   lo;
      logic signed [CW:0]   hi;
   } axis_type;

   typedef struct packed {
      logic              hit;
      logic signed [TW:0] tmin;
      logic signed [TW:0] tmax;
      axis_type [2:0]    ax;
   } carry_type;

   typedef struct packed {
      carry_type c;
      logic      sl;
      logic      sh;
      logic      pp;
      logic      oo;
      logic      nl;
      logic      nh;
   } side_type;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   logic [sbsi_pkg::THR_WIDTH-1:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) thr_ff <= sbsi_pkg::THR_WIDTH'(1);
      else if (csr_valid) thr_ff <= csr_data;
   end

   logic [DEPTH-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
   end

   // setup stage
   carry_type c0_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         logic [CW-2:0] half;
         half = req_tdata[9*CW +: CW-1] >> 1;
         c0_ff.hit  <= 1'b1;
         c0_ff.tmin <= '0;
         c0_ff.tmax <= TONE;
         for (int a = 0; a < 3; a++) begin
            c0_ff.ax[a].s  <= req_tdata[a*CW +: CW];
            c0_ff.ax[a].d  <= (CW+1)'($signed(req_tdata[(3+a)*CW +: CW]))
                            - (CW+1)'($signed(req_tdata[a*CW +: CW]));
            c0_ff.ax[a].lo <= (CW+1)'($signed(req_tdata[(6+a)*CW +: CW]))
                            - (CW+1)'($signed({1'b0, half}));
            c0_ff.ax[a].hi <= (CW+1)'($signed(req_tdata[(6+a)*CW +: CW]))
                            + (CW+1)'($signed({1'b0, half}));
         end
      end
   end

   carry_type ci [0:3];
   assign ci[0] = c0_ff;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic signed [CW+1:0] nlo, nhi;
      logic signed [CW:0]   dd;
      logic [NW-1:0] alo, ahi, ad;
      logic sat_lo, sat_hi, par, outside;
      logic [NW-1:0] rl [0:NC];
      logic [NW-1:0] rh [0:NC];
      logic [NW-1:0] dl [0:NC];
      logic [NW-1:0] dh [0:NC];
      logic [QW-1:0] ql [0:NC];
      logic [QW-1:0] qh [0:NC];
      side_type      sd_in;
      side_type      sd_ff [0:NC-1];
      carry_type     prev, res;
      logic [TW:0]   mlo, mhi;
      logic signed [TW:0] t1, t2, lo_t, hi_t, tmn, tmx;

      assign dd  = ci[a].ax[a].d;
      assign nlo = (CW+2)'(ci[a].ax[a].lo) - (CW+2)'(ci[a].ax[a].s);
      assign nhi = (CW+2)'(ci[a].ax[a].hi) - (CW+2)'(ci[a].ax[a].s);
      assign alo = nlo[CW+1] ? NW'(-nlo) : NW'(nlo);
      assign ahi = nhi[CW+1] ? NW'(-nhi) : NW'(nhi);
      assign ad  = dd[CW] ? NW'(-dd) : NW'(dd);
      assign sat_lo = alo >= (ad << 1);
      assign sat_hi = ahi >= (ad << 1);
      assign par = (ad == '0) || (ad < NW'(thr_ff));
      assign outside = ((CW+1)'(ci[a].ax[a].s) < ci[a].ax[a].lo)
                    || ((CW+1)'(ci[a].ax[a].s) > ci[a].ax[a].hi);

      // divide by 2*ad so the first cell yields the integer bit
      assign rl[0] = sat_lo ? '0 : alo;
      assign rh[0] = sat_hi ? '0 : ahi;
      assign dl[0] = ad << 1;
      assign dh[0] = ad << 1;
      assign ql[0] = '0;
      assign qh[0] = '0;

      always_comb begin
         sd_in.c  = ci[a];
         sd_in.sl = sat_lo;
         sd_in.sh = sat_hi;
         sd_in.pp = par;
         sd_in.oo = outside;
         sd_in.nl = nlo[CW+1] != dd[CW];
         sd_in.nh = nhi[CW+1] != dd[CW];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sd_ff[0] <= sd_in;
            for (int k = 1; k < NC; k++) sd_ff[k] <= sd_ff[k-1];
         end
      end

      for (genvar k = 0; k < NC; k++) begin : g_cell
         sbsi_div_cell #(.NW(NW), .QW(QW)) u_lo (
            .clock(clock), .advance(adv), .rem_in(rl[k]), .den_in(dl[k]),
            .quo_in(ql[k]), .rem_ff(rl[k+1]), .den_ff(dl[k+1]), .quo_ff(ql[k+1]));
         sbsi_div_cell #(.NW(NW), .QW(QW)) u_hi (
            .clock(clock), .advance(adv), .rem_in(rh[k]), .den_in(dh[k]),
            .quo_in(qh[k]), .rem_ff(rh[k+1]), .den_ff(dh[k+1]), .quo_ff(qh[k+1]));
      end

      always_comb begin
         prev = sd_ff[NC-1].c;
         mlo = sd_ff[NC-1].sl ? (TW+1)'(TSAT) : {1'b0, ql[NC]};
         mhi = sd_ff[NC-1].sh ? (TW+1)'(TSAT) : {1'b0, qh[NC]};
         t1 = sd_ff[NC-1].nl ? -$signed(mlo) : $signed(mlo);
         t2 = sd_ff[NC-1].nh ? -$signed(mhi) : $signed(mhi);
         lo_t = (t1 > t2) ? t2 : t1;
         hi_t = (t1 > t2) ? t1 : t2;
         tmn = (lo_t > prev.tmin) ? lo_t : prev.tmin;
         tmx = (hi_t < prev.tmax) ? hi_t : prev.tmax;
         res = prev;
         if (prev.hit) begin
            if (sd_ff[NC-1].pp) begin
               if (sd_ff[NC-1].oo) res.hit = 1'b0;
            end else begin
               res.tmin = tmn;
               res.tmax = tmx;
               if (tmn > tmx) res.hit = 1'b0;
            end
         end
      end
      assign ci[a+1] = res;
   end

   // point stages: register, multiply
   carry_type p_ff, m_ff;
   logic signed [CW+TW+1:0] prod_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff <= ci[3];
         m_ff <= p_ff;
         for (int a = 0; a < 3; a++)
            prod_ff[a] <= (CW+TW+2)'(p_ff.ax[a].d) * (CW+TW+2)'(p_ff.tmin);
      end
   end

   logic [OW-1:0] out_ff;
   logic          hit_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         logic signed [CW+TW+1:0] pt;
         logic signed [CW-1:0] pc [3];
         for (int a = 0; a < 3; a++) begin
            pt = (CW+TW+2)'(m_ff.ax[a].s) + (prod_ff[a] >>> T_FRAC_BITS);
            if (pt > PMAX)
               pc[a] = {1'b0, {(CW-1){1'b1}}};
            else if (pt < PMIN)
               pc[a] = {1'b1, {(CW-1){1'b0}}};
            else
               pc[a] = pt[CW-1:0];
            if (!m_ff.hit) pc[a] = '0;
         end
         out_ff <= OW'({pc[2], pc[1], pc[0], m_ff.tmax[TW-1:0], m_ff.tmin[TW-1:0]});
         hit_ff <= m_ff.hit;
      end
   end

   assign rsp_tvalid = vld_ff[DEPTH-1];
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = hit_ff;
endmodule
`default_nettype wire
